FILE: hdl/ptmw_pkg.sv
// Shared types, constants and the microcode table of the page table map walker.
`default_nettype none

package ptmw_pkg;

	localparam int VA_W       = 48;
	localparam int PA_W       = 52;
	localparam int FRAME_W    = 40;
	localparam int FLAG_W     = 3;
	localparam int ENTRY_W    = FRAME_W + FLAG_W;
	localparam int IDX_W      = 9;
	localparam int OFFSET_W   = 12;
	localparam int ENTRIES    = 512;
	localparam int LEVELS     = 4;
	localparam int TU_W       = 7;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_FETCH = 4'd0;
	localparam logic [STEP_W-1:0] STEP_RD4   = 4'd1;
	localparam logic [STEP_W-1:0] STEP_WK4   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_RD3   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_WK3   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_RD2   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_WK2   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_RD1   = 4'd7;
	localparam logic [STEP_W-1:0] STEP_LEAF  = 4'd8;
	localparam logic [STEP_W-1:0] STEP_DONE  = 4'd9;

	localparam logic [1:0] ST_MAPPED  = 2'd0;
	localparam logic [1:0] ST_SKIPPED = 2'd1;
	localparam logic [1:0] ST_NOTABLE = 2'd2;

	typedef enum logic [2:0] {
		OP_FETCH = 3'd0,
		OP_READ  = 3'd1,
		OP_WALK  = 3'd2,
		OP_LEAF  = 3'd3,
		OP_DONE  = 3'd4
	} ptmw_op_t;

	// lvl is the table level minus one; alt is the jump target on failure
	typedef struct packed {
		ptmw_op_t          op;
		logic [1:0]        lvl;
		logic [STEP_W-1:0] nxt;
		logic [STEP_W-1:0] alt;
	} ptmw_ctrl_t;

	function automatic ptmw_ctrl_t ptmw_ucode(input logic [STEP_W-1:0] step);
		ptmw_ctrl_t w;
		unique case (step)
			STEP_FETCH: w = '{OP_FETCH, 2'd3, STEP_RD4,   STEP_RD4};
			STEP_RD4:   w = '{OP_READ,  2'd3, STEP_WK4,   STEP_WK4};
			STEP_WK4:   w = '{OP_WALK,  2'd3, STEP_RD3,   STEP_DONE};
			STEP_RD3:   w = '{OP_READ,  2'd2, STEP_WK3,   STEP_WK3};
			STEP_WK3:   w = '{OP_WALK,  2'd2, STEP_RD2,   STEP_DONE};
			STEP_RD2:   w = '{OP_READ,  2'd1, STEP_WK2,   STEP_WK2};
			STEP_WK2:   w = '{OP_WALK,  2'd1, STEP_RD1,   STEP_DONE};
			STEP_RD1:   w = '{OP_READ,  2'd0, STEP_LEAF,  STEP_LEAF};
			STEP_LEAF:  w = '{OP_LEAF,  2'd0, STEP_DONE,  STEP_DONE};
			STEP_DONE:  w = '{OP_DONE,  2'd0, STEP_FETCH, STEP_FETCH};
			default:    w = '{OP_DONE,  2'd0, STEP_FETCH, STEP_FETCH};
		endcase
		return w;
	endfunction

	function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
							 input logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		unique case (lvl)
			2'd0: idx = va[OFFSET_W             +: IDX_W];
			2'd1: idx = va[OFFSET_W + IDX_W     +: IDX_W];
			2'd2: idx = va[OFFSET_W + 2 * IDX_W +: IDX_W];
			2'd3: idx = va[OFFSET_W + 3 * IDX_W +: IDX_W];
			default: idx = '0;
		endcase
		return idx;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/ptmw_pool_ram.sv
// Table pool memory: one write port, one read port with registered data.
`default_nettype none

module ptmw_pool_ram #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15,
	parameter int DW    = 43
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/page_table_map_walker_unit.sv
// Page table map walker: installs four-level page mappings in an internal table pool.
//
// Requests arrive on the s_axis channel, one mapping per transaction; results
// leave on m_axis, one per request, in request order. Register pool_base_frame
// sits at APB byte address 0; the user must write it only while idle, unenforced by the block.
// A request runs through a microcode program of ten steps: fetch, then a read
// and an evaluate step for each of the four levels (each read waits on the
// registered pool RAM port), then a step that loads the result register.
// A walk that runs out of tables jumps straight to the final step. A request is
// accepted only in the fetch step, so the walker takes no new request before the
// last one has left the final step; the single pool RAM port and the chain of
// dependent table reads set this pace.
// After reset the pool RAM is cleared one entry per cycle, all 512 * POOL_TABLES
// entries (32768 at the default); s_axis_tready stays low until it is done,
// while register writes are taken as usual.
// The result register lets the next request be accepted while a result waits;
// if m_axis_tready stays low, that next request halts in its final step until
// the result register frees, so no result is lost.
`default_nettype none

module page_table_map_walker_unit
	import ptmw_pkg::*;
#(
	parameter int POOL_TABLES = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// APB configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic      [63:0]  prdata,
	output logic              pready,
	// request stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [103:0] s_axis_tdata,  // virt_addr[47:0], phys_addr[99:48], perm_flags[102:100]
	input  wire logic         s_axis_tuser,  // func
	// result stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic      [111:0] m_axis_tdata,  // leaf_entry[51:0], flush_valid[52], flush_addr[100:53], tables_used[107:101]
	output logic      [1:0]   m_axis_tuser   // status
);

	localparam int TW    = $clog2(POOL_TABLES);
	localparam int NW    = $clog2(POOL_TABLES + 1);
	localparam int AW    = TW + IDX_W;
	localparam int DEPTH = POOL_TABLES * ENTRIES;
	localparam logic REG_POOL_BASE = 1'b0;

	logic [STEP_W-1:0]  step_q, step_d;
	logic               clr_q;
	logic [AW-1:0]      clr_addr_q;
	logic [FRAME_W-1:0] base_q;
	logic               func_q;
	logic [VA_W-1:0]    va_q;
	logic [FRAME_W-1:0] frame_q;
	logic [FLAG_W-1:0]  flags_q;
	logic [TW-1:0]      table_q;
	logic [NW-1:0]      next_free_q;
	logic [1:0]         status_q;
	logic               m_valid_q;
	logic [111:0]       m_data_q;
	logic [1:0]         m_user_q;

	ptmw_ctrl_t         ctrl;
	logic [IDX_W-1:0]   idx;
	logic [AW-1:0]      slot;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               rd_present;
	logic [FRAME_W-1:0] rd_frame;
	logic [FRAME_W-1:0] off;
	logic               ptr_ok;
	logic               pool_full;
	logic [TW-1:0]      fresh_tbl;
	logic               leaf_keep;
	logic               out_free;
	logic               s_accept;
	logic               cfg_wr;
	logic               walk_alloc;
	logic               walk_fail;
	logic               mapped;
	logic [NW+TU_W-1:0] nf_ext;
	logic [51:0]        leaf_word;

	assign ctrl       = ptmw_ucode(step_q);
	assign idx        = level_index(va_q, ctrl.lvl);
	assign slot       = {table_q, idx};
	assign rd_present = ram_rdata[0];
	assign rd_frame   = ram_rdata[ENTRY_W-1:FLAG_W];
	assign off        = rd_frame - base_q;
	assign ptr_ok     = off < FRAME_W'(POOL_TABLES);
	assign pool_full  = next_free_q == NW'(POOL_TABLES);
	assign fresh_tbl  = next_free_q[TW-1:0];
	assign leaf_keep  = !func_q && (rd_frame != '0);
	assign out_free   = !m_valid_q || m_axis_tready;
	assign s_accept   = s_axis_tvalid && s_axis_tready;
	assign cfg_wr     = psel && penable && pwrite && pready;
	assign walk_alloc = (ctrl.op == OP_WALK) && !rd_present && !pool_full;
	assign walk_fail  = (ctrl.op == OP_WALK) && (rd_present ? !ptr_ok : pool_full);
	assign mapped     = status_q == ST_MAPPED;
	assign nf_ext     = {{TU_W{1'b0}}, next_free_q};
	assign leaf_word  = mapped ? {frame_q, {(OFFSET_W - FLAG_W){1'b0}}, flags_q} : '0;

	assign s_axis_tready = (ctrl.op == OP_FETCH) && !clr_q;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign pready        = 1'b1;
	assign prdata        = (paddr[3] == REG_POOL_BASE) ? {24'b0, base_q} : '0;

	// sequencer branch and pool write port
	always_comb begin
		step_d    = step_q;
		ram_we    = 1'b0;
		ram_waddr = slot;
		ram_wdata = {frame_q, flags_q};
		unique case (ctrl.op)
			OP_FETCH: begin
				if (s_accept) step_d = ctrl.nxt;
			end
			OP_READ: begin
				step_d = ctrl.nxt;
			end
			OP_WALK: begin
				if (walk_fail) begin
					step_d = ctrl.alt;
				end else begin
					step_d = ctrl.nxt;
				end
				if (walk_alloc) begin
					ram_we    = 1'b1;
					ram_wdata = {base_q + FRAME_W'(next_free_q), flags_q};
				end
			end
			OP_LEAF: begin
				step_d = ctrl.nxt;
				ram_we = !leaf_keep;
			end
			OP_DONE: begin
				if (out_free) step_d = ctrl.nxt;
			end
			default: begin
				step_d = STEP_FETCH;
			end
		endcase
		// the clearing pass owns the write port
		if (clr_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end
	end

	ptmw_pool_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (ENTRY_W)
	) u_pool (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctrl.op == OP_READ),
		.raddr (slot),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_FETCH;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			base_q      <= '0;
			next_free_q <= NW'(1);
			m_valid_q   <= 1'b0;
		end else begin
			step_q <= step_d;
			if (clr_q) begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clr_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + AW'(1);
				end
			end
			if (cfg_wr && paddr[3] == REG_POOL_BASE) begin
				base_q <= pwdata[FRAME_W-1:0];
			end
			if (walk_alloc) begin
				next_free_q <= next_free_q + NW'(1);
			end
			if (ctrl.op == OP_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			func_q  <= s_axis_tuser;
			va_q    <= s_axis_tdata[VA_W-1:0];
			frame_q <= s_axis_tdata[VA_W+PA_W-1:VA_W+OFFSET_W];
			flags_q <= s_axis_tdata[VA_W+PA_W+FLAG_W-1:VA_W+PA_W];
			table_q <= '0;
		end
		if (ctrl.op == OP_WALK) begin
			if (rd_present) begin
				table_q <= off[TW-1:0];
			end else begin
				table_q <= fresh_tbl;
			end
		end
		if (walk_fail) begin
			status_q <= ST_NOTABLE;
		end else if (ctrl.op == OP_LEAF) begin
			status_q <= leaf_keep ? ST_SKIPPED : ST_MAPPED;
		end
		if (ctrl.op == OP_DONE && out_free) begin
			m_user_q <= status_q;
			m_data_q <= {4'b0, nf_ext[TU_W-1:0], mapped ? va_q : {VA_W{1'b0}},
				     mapped, leaf_word};
		end
	end

	// the bump allocator never passes the pool size
	a_next_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= NW'(POOL_TABLES) && next_free_q != '0)
		else $error("allocator count out of range");

	// an accepted request always starts the walk at the root level read
	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (step_q == STEP_RD4) && (table_q == '0))
		else $error("walk did not start after request");

	// a result appears only out of the final microcode step
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(ctrl.op == OP_DONE))
		else $error("result loaded outside final step");

	// no request is taken while the pool is still being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !s_accept && (step_q == STEP_FETCH))
		else $error("request accepted during clearing pass");

endmodule

`default_nettype wire
